@@ rtl/mtrd_pkg.sv @@
// Shared constants, register codes and sequencer states of the multi-tap ring delay.
package mtrd_pkg;

  localparam int unsigned TAPS_DEF       = 8;
  localparam int unsigned MEM_DEPTH_DEF  = 65536;
  localparam int unsigned RING_LEN_RESET = 65536;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned TAP_IDX_W    = 3;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned DELAY_W      = 32;
  localparam int unsigned RING_LEN_W   = 17;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_RING_LENGTH = 3'd1,
    REG_TAP_MASK    = 3'd2,
    REG_DELAYS_01   = 3'd3,
    REG_DELAYS_23   = 3'd4,
    REG_DELAYS_45   = 3'd5,
    REG_DELAYS_67   = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_ADVANCE = 5'b00100,
    ST_TAP     = 5'b01000,
    ST_LOAD    = 5'b10000
  } state_e;

endpackage

@@ rtl/mtrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtrd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mtrd_addr_unit.sv @@
// Shared ring address unit: base minus a saturated offset, wrapped into the ring.
module mtrd_addr_unit #(
  parameter int unsigned MEMORY_DEPTH = mtrd_pkg::MEM_DEPTH_DEF,
  localparam int unsigned AW = $clog2(MEMORY_DEPTH),
  localparam int unsigned LW = $clog2(MEMORY_DEPTH + 1)
) (
  input  logic [AW-1:0]                base_i,
  input  logic [mtrd_pkg::DELAY_W-1:0] offs_i,
  input  logic [LW-1:0]                len_i,
  output logic [AW-1:0]                addr_o
);

  import mtrd_pkg::*;

  localparam int unsigned SW = LW + 1;

  logic [LW-1:0] offs_sat;
  logic [SW-1:0] sum;

  always_comb begin
    // saturate the offset to the ring length
    offs_sat = (offs_i > DELAY_W'(len_i)) ? len_i : LW'(offs_i);
    if (offs_sat > LW'(base_i)) begin
      sum = SW'(base_i) + SW'(len_i) - SW'(offs_sat);
    end else begin
      sum = SW'(base_i) - SW'(offs_sat);
    end
    addr_o = (sum >= SW'(len_i)) ? '0 : AW'(sum);
  end

endmodule

@@ rtl/multi_tap_ring_delay.sv @@
// Multi-tap ring delay: top level with sequencer, registers, delay RAM and output stage.
// Sequence: a beat accepted while enabled is written to the ring, ADVANCE moves the head, TAP
//   issues the first tap read, each LOAD fills the output register and issues the next read while
//   the output is free; no tap enabled returns to IDLE, and a new beat is taken only in IDLE.
// The single RAM read port gives one tap read per cycle while the output is not stalled.
// Reset: registers return to their reset values, then a clearing pass writes zero to all
//   MEMORY_DEPTH RAM entries before the first input beat is taken.
module multi_tap_ring_delay #(
  parameter int unsigned TAPS         = mtrd_pkg::TAPS_DEF,
  parameter int unsigned MEMORY_DEPTH = mtrd_pkg::MEM_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mtrd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mtrd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mtrd_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] in_sample
  input  logic                            s_axis_tuser,  // [0] in_present
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mtrd_pkg::SAMPLE_W-1:0]   m_axis_tdata,  // [15:0] out_sample
  output logic [mtrd_pkg::TAP_IDX_W-1:0]  m_axis_tuser,  // [2:0] tap_index
  output logic                            m_axis_tlast   // last_of_run
);

  import mtrd_pkg::*;

  localparam int unsigned AW = $clog2(MEMORY_DEPTH);
  localparam int unsigned LW = $clog2(MEMORY_DEPTH + 1);
  localparam int unsigned TW = (TAPS > 1) ? $clog2(TAPS) : 1;
  // ring length after reset, saturated to the memory that exists
  localparam int unsigned LEN_RESET =
    (RING_LEN_RESET > MEMORY_DEPTH) ? MEMORY_DEPTH : RING_LEN_RESET;

  // ---------------------------------------------------------------------------
  // Configuration registers. The ring length is kept in its effective form:
  // zero becomes one, anything above the memory depth saturates to it.
  // ---------------------------------------------------------------------------
  logic                enable_q;
  logic [LW-1:0]       len_q;
  logic [MASK_W-1:0]   mask_q;
  logic [DELAY_W-1:0]  delay_q [TAPS];
  logic                cfg_fire;
  logic [RING_LEN_W-1:0] ring_len_wr;
  logic [LW-1:0]       len_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    ring_len_wr = cfg_data_i[RING_LEN_W-1:0];
    if (ring_len_wr == '0) begin
      len_wr = LW'(1);
    end else if (32'(ring_len_wr) > 32'(MEMORY_DEPTH)) begin
      len_wr = LW'(MEMORY_DEPTH);
    end else begin
      len_wr = LW'(ring_len_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      len_q    <= LW'(LEN_RESET);
      mask_q   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_ENABLE:      enable_q <= cfg_data_i[0];
        REG_RING_LENGTH: len_q    <= len_wr;
        REG_TAP_MASK:    mask_q   <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Each delay register feeds an even tap from its low word, an odd tap from its high word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TAPS; t++) begin
        delay_q[t] <= '0;
      end
    end else if (cfg_fire) begin
      for (int t = 0; t < TAPS; t++) begin
        if (cfg_index_i == CFG_IDX_W'(int'(REG_DELAYS_01) + (t >> 1))) begin
          delay_q[t] <= ((t & 1) != 0) ? cfg_data_i[2*DELAY_W-1:DELAY_W]
                                       : cfg_data_i[DELAY_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [AW-1:0]   head_q, head_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [TAPS-1:0] rem_q, rem_d;      // enabled taps not yet read
  logic [TW-1:0]   rd_tap_q, rd_tap_d;
  logic            rd_last_q, rd_last_d;

  logic            in_fire;
  logic [AW-1:0]   head_wr;
  logic [TW-1:0]   next_tap;
  logic [TAPS-1:0] rem_after;
  logic            issue;
  logic            load;

  // shared address unit
  logic [AW-1:0]      unit_base;
  logic [DELAY_W-1:0] unit_offs;
  logic [AW-1:0]      unit_addr;

  // RAM ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]  out_sample_q;
  logic [TAP_IDX_W-1:0] out_tap_q;
  logic                 out_last_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // drop a head left beyond a shortened ring back to slot zero
  assign head_wr = (LW'(head_q) >= len_q) ? '0 : head_q;

  // lowest enabled tap still pending
  always_comb begin
    next_tap = '0;
    for (int t = TAPS - 1; t >= 0; t--) begin
      if (rem_q[t]) begin
        next_tap = TW'(t);
      end
    end
    rem_after = rem_q & ~(TAPS'(1) << next_tap);
  end

  assign load  = (state_q == ST_LOAD) && (!out_valid_q || m_axis_tready);
  assign issue = (state_q == ST_TAP) || (load && !rd_last_q);

  // Advance the head as head - (len - 1) wrapped, i.e. head + 1 modulo len;
  // tap reads use head - delay wrapped.
  always_comb begin
    unit_base = head_q;
    if (state_q == ST_ADVANCE) begin
      unit_offs = DELAY_W'(len_q - LW'(1));
    end else begin
      unit_offs = delay_q[next_tap];
    end
  end

  mtrd_addr_unit #(
    .MEMORY_DEPTH(MEMORY_DEPTH)
  ) u_addr (
    .base_i(unit_base),
    .offs_i(unit_offs),
    .len_i (len_q),
    .addr_o(unit_addr)
  );

  // RAM write: clearing pass after reset, otherwise a sample accepted while enabled
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_wr;
    ram_wdata = s_axis_tuser ? s_axis_tdata : '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (in_fire && enable_q) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = issue;

  mtrd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MEMORY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(unit_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    clr_d     = clr_q;
    rem_d     = rem_q;
    rd_tap_d  = rd_tap_q;
    rd_last_d = rd_last_q;

    if (issue) begin
      rd_tap_d  = next_tap;
      rd_last_d = (rem_after == '0);
      rem_d     = rem_after;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MEMORY_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // a beat taken while disabled is dropped
        if (in_fire && enable_q) begin
          head_d  = head_wr;
          state_d = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        head_d = unit_addr;
        rem_d  = mask_q[TAPS-1:0];
        state_d = (mask_q[TAPS-1:0] == '0) ? ST_IDLE : ST_TAP;
      end
      ST_TAP: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load && rd_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      head_q    <= '0;
      clr_q     <= '0;
      rem_q     <= '0;
      rd_tap_q  <= '0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      clr_q     <= clr_d;
      rem_q     <= rem_d;
      rd_tap_q  <= rd_tap_d;
      rd_last_q <= rd_last_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished beat while the sequencer moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sample_q <= ram_rdata;
      out_tap_q    <= TAP_IDX_W'(rd_tap_q);
      out_last_q   <= rd_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_tap_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("delay RAM written and read in the same cycle");

  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAP) |-> (LW'(head_q) < len_q))
    else $error("write head outside the ring during tap reads");

  a_accept_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && enable_q) |=> (state_q == ST_ADVANCE))
    else $error("accepted beat did not advance the head");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && rd_last_q) |=> (state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("last tap result did not close the run");

endmodule

@@ tb/sv/multi_tap_ring_delay_tb.sv @@
// Self-checking testbench for the multi-tap ring delay: directed table, random sweeps, stalls.
`timescale 1ns / 100ps

module multi_tap_ring_delay_tb;
  import mtrd_pkg::*;

  // The clearing pass after reset takes no input beat; the limit leaves it room.
  localparam int unsigned STALL_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned BURST_ITEMS   = 20;
  localparam int unsigned IGNORED_ITEMS = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;  // past the register list

  localparam int unsigned SEND_IDLE [4]  = '{0, 64, 0, 14};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 64, 14};
  localparam cfg_idx_e DELAY_REGS [4] = '{REG_DELAYS_01, REG_DELAYS_23, REG_DELAYS_45,
                                           REG_DELAYS_67};

  typedef struct packed {
    logic [SAMPLE_W-1:0]  smp;
    logic [TAP_IDX_W-1:0] tap;
    logic                 last;
  } tap_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ONE} row_check_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   smp;
    logic                  pres;
    row_check_e            check;
    tap_result_t           typed;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic [TAP_IDX_W-1:0]  m_axis_tuser;
  logic                  m_axis_tlast;

  // Predictor copy of the delay memory, write head and register file.
  logic [SAMPLE_W-1:0]   ring_mem [MEM_DEPTH_DEF];
  int unsigned           ring_head;
  logic                  sh_enable;
  logic [RING_LEN_W-1:0] sh_ring_len;
  logic [MASK_W-1:0]     sh_tap_mask;
  logic [CFG_DATA_W-1:0] sh_delays [4];

  tap_result_t pending_taps [$];
  stim_row_t   dir_rows [$];

  int unsigned error_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  multi_tap_ring_delay uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_len(logic [RING_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MEM_DEPTH_DEF) return MEM_DEPTH_DEF;
    return len;
  endfunction

  function automatic logic [DELAY_W-1:0] tap_delay_of(int unsigned t);
    logic [CFG_DATA_W-1:0] pair;
    pair = sh_delays[t / 2];
    return (t % 2 == 1) ? pair[63:32] : pair[31:0];
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ENABLE:      sh_enable   = data[0];
      REG_RING_LENGTH: sh_ring_len = data[RING_LEN_W-1:0];
      REG_TAP_MASK:    sh_tap_mask = data[MASK_W-1:0];
      REG_DELAYS_01:   sh_delays[0] = data;
      REG_DELAYS_23:   sh_delays[1] = data;
      REG_DELAYS_45:   sh_delays[2] = data;
      REG_DELAYS_67:   sh_delays[3] = data;
      default: ;
    endcase
  endfunction

  // When enabled, store one sample, advance the head, queue one tap read per enabled tap.
  function automatic void advance_ring(logic [SAMPLE_W-1:0] smp, logic pres);
    int unsigned len, h, d, rd, last_tap;
    tap_result_t res;
    if (!sh_enable) return;
    len = eff_len(sh_ring_len);
    h = (ring_head >= len) ? 0 : ring_head;
    ring_mem[h] = pres ? smp : '0;
    h = h + 1;
    if (h >= len) h = 0;
    ring_head = h;
    last_tap = 0;
    for (int t = 0; t < TAPS_DEF; t++)
      if (sh_tap_mask[t]) last_tap = t;
    for (int t = 0; t < TAPS_DEF; t++) begin
      if (!sh_tap_mask[t]) continue;
      d = tap_delay_of(t);
      if (d > len) d = len;
      rd = (d > h) ? h + len - d : h - d;
      if (rd >= len) rd = 0;
      res.smp  = ring_mem[rd];
      res.tap  = TAP_IDX_W'(t);
      res.last = (t == last_tap);
      pending_taps.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    shadow_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one sample beat; tvalid stays up if the next beat follows without a gap.
  task automatic push_sample(logic [SAMPLE_W-1:0] smp, logic pres, row_check_e check,
                             tap_result_t typed);
    int unsigned n0;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= pres;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    n0 = pending_taps.size();
    advance_ring(smp, pres);
    // Table rows with a typed answer replace what the predictor queued.
    if (check != EXP_PREDICT) begin
      while (pending_taps.size() > n0) void'(pending_taps.pop_back());
      if (check == EXP_ONE) pending_taps.push_back(typed);
    end
  endtask

  // Drop tvalid, drain every expected beat, then let the sequencer run out.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay(int unsigned len_eff);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return DELAY_W'($urandom_range(len_eff + 1));
    if (r < 65) return '0;
    if (r < 80) return '1;
    return DELAY_W'($urandom);
  endfunction

  // Pick a random ring setting; busy forces every tap on so the output backs up.
  task automatic random_setup(bit busy, output bit en);
    logic [CFG_DATA_W-1:0] word;
    logic [RING_LEN_W-1:0] len;
    int unsigned           r;
    r = $urandom_range(99);
    if (r < 60)      len = RING_LEN_W'($urandom_range(24, 1));
    else if (r < 70) len = '0;
    else if (r < 80) len = RING_LEN_W'(MEM_DEPTH_DEF);
    else if (r < 90) len = RING_LEN_W'($urandom_range(131071, 65537));
    else             len = RING_LEN_W'($urandom_range(65535, 25));
    word = {$urandom, $urandom};
    word[RING_LEN_W-1:0] = len;
    write_reg(REG_RING_LENGTH, word);

    r = $urandom_range(99);
    word = {$urandom, $urandom};
    if (busy || (r >= 15 && r < 30)) word[MASK_W-1:0] = '1;
    else if (r < 15)                 word[MASK_W-1:0] = '0;
    write_reg(REG_TAP_MASK, word);

    for (int p = 0; p < 4; p++)
      write_reg(DELAY_REGS[p], {pick_delay(eff_len(len)), pick_delay(eff_len(len))});
    if ($urandom_range(9) == 0) write_reg(CFG_IDX_SPARE, {$urandom, $urandom});

    en = busy || ($urandom_range(9) != 0);
    word = {$urandom, $urandom};
    word[0] = en;
    write_reg(REG_ENABLE, word);
  endtask

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = data;
    row.check = EXP_PREDICT;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_smp(logic [SAMPLE_W-1:0] smp, logic pres, row_check_e check,
                                  tap_result_t typed);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_SAMPLE;
    row.smp   = smp;
    row.pres  = pres;
    row.check = check;
    row.typed = typed;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- receiver side

  // Stall at random, or hold off for a long stretch when one is requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output beat with the oldest expected tap read.
  always @(posedge clk_i) begin : check_taps
    tap_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_taps.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat: expected none, got sample %h tap %0d last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = pending_taps.pop_front();
        if (m_axis_tdata !== want.smp || m_axis_tuser !== want.tap ||
            m_axis_tlast !== want.last) begin
          error_count++;
          $display("%0t: mismatch: expected sample %h tap %0d last %b, got %h %0d %b",
                   $time, want.smp, want.tap, want.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_taps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    bit en;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    foreach (sh_delays[i]) sh_delays[i] = '0;
    ring_head   = 0;
    sh_enable   = 1'b0;
    sh_ring_len = RING_LEN_W'(RING_LEN_RESET);
    sh_tap_mask = '0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Disabled after reset: the beat is taken and dropped.
    row_cfg(REG_TAP_MASK, 64'h1);
    row_smp(16'h1234, 1'b1, EXP_NONE, '0);
    // Unused index leaves every register alone; only bit 0 of the enable word counts.
    row_cfg(CFG_IDX_SPARE, '1);
    row_cfg(REG_ENABLE, '1);
    // Delay zero reads the oldest slot, still zero after the clearing pass.
    row_smp(16'h7FFF, 1'b1, EXP_ONE, {16'h0000, 3'd0, 1'b1});
    // Delay one reads back the sample just stored; an absent sample stores zero.
    row_cfg(REG_DELAYS_01, 64'd1);
    row_smp(16'h8000, 1'b1, EXP_ONE, {16'h8000, 3'd0, 1'b1});
    row_smp(16'h7FFF, 1'b0, EXP_ONE, {16'h0000, 3'd0, 1'b1});
    row_smp(16'hFFFF, 1'b1, EXP_ONE, {16'hFFFF, 3'd0, 1'b1});
    // Delay past the ring length saturates onto the oldest slot.
    row_cfg(REG_DELAYS_01, 64'hFFFF_FFFF);
    row_smp(16'h0001, 1'b1, EXP_ONE, {16'h0000, 3'd0, 1'b1});
    // Shrink the ring below the head so it restarts at zero; run all taps.
    row_cfg(REG_RING_LENGTH, 64'd4);
    row_cfg(REG_TAP_MASK, 64'hFF);
    row_cfg(REG_DELAYS_01, {32'd1, 32'd0});
    row_cfg(REG_DELAYS_23, {32'd3, 32'd2});
    row_cfg(REG_DELAYS_45, {32'd5, 32'd4});
    row_cfg(REG_DELAYS_67, {32'h0001_0000, 32'hFFFF_FFFF});
    row_smp(16'h0102, 1'b1, EXP_PREDICT, '0);
    row_smp(16'hFEDC, 1'b1, EXP_PREDICT, '0);
    row_smp(16'h5555, 1'b0, EXP_PREDICT, '0);
    row_smp(16'hAAAA, 1'b1, EXP_PREDICT, '0);
    row_smp(16'h8001, 1'b1, EXP_PREDICT, '0);
    // Ring length zero behaves as one; then one itself.
    row_cfg(REG_RING_LENGTH, 64'd0);
    row_smp(16'h1111, 1'b1, EXP_PREDICT, '0);
    row_smp(16'h2222, 1'b1, EXP_PREDICT, '0);
    row_cfg(REG_RING_LENGTH, 64'd1);
    row_smp(16'h3333, 1'b1, EXP_PREDICT, '0);
    // Length beyond the memory saturates; tap 7 alone, one sample back.
    row_cfg(REG_RING_LENGTH, 64'h1_FFFF);
    row_cfg(REG_TAP_MASK, 64'h80);
    row_cfg(REG_DELAYS_67, {32'd1, 32'd0});
    row_smp(16'h5A5A, 1'b1, EXP_ONE, {16'h5A5A, 3'd7, 1'b1});
    // No tap enabled: the sample is stored but nothing comes out.
    row_cfg(REG_TAP_MASK, 64'h0);
    row_smp(16'hA5A5, 1'b1, EXP_NONE, '0);
    row_cfg(REG_TAP_MASK, 64'hFF);
    row_smp(16'h0F0F, 1'b0, EXP_PREDICT, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i != 0 && dir_rows[i-1].kind == ROW_SAMPLE) wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].smp, dir_rows[i].pres, dir_rows[i].check,
                    dir_rows[i].typed);
      end
    end
    wait_idle();

    // Random sweeps: one idling pattern per phase, several ring settings per phase.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      for (int b = 0; b < 4; b++) begin
        random_setup(ph == 0 && b == 0, en);
        // Hold off the receiver while the sender keeps offering, so the input backs up.
        if (ph == 0 && b == 0) hold_requests++;
        repeat (en ? BURST_ITEMS : IGNORED_ITEMS)
          push_sample(SAMPLE_W'($urandom), 1'($urandom_range(1)), EXP_PREDICT, '0);
        wait_idle();
      end
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mtrd_pkg.sv
rtl/mtrd_ram.sv
rtl/mtrd_addr_unit.sv
rtl/multi_tap_ring_delay.sv
tb/sv/multi_tap_ring_delay_tb.sv
